// File: hw/rtl/lbp_riu2_pixel_stream_assert.svh
// ============================================================================
// LBP riu2 pixel stream assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ============================================================================
`ifndef LBP_RIU2_PIXEL_STREAM_ASSERT_SVH
`define LBP_RIU2_PIXEL_STREAM_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbp assertion failed");

// next-cycle implication
`define LBP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbp assertion failed");

`else

`define LBP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LBP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hw/rtl/lbp_pkg.sv
// ============================================================================
// LBP package
// Shared constants and types of the LBP riu2 pixel stream block.
// ============================================================================
package lbp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_CFG_W = 12;
    localparam int ROW_W       = 12;
    localparam int PIXEL_W     = 8;
    localparam int LABEL_W     = 4;
    localparam int RING_N      = 8;
    localparam int CNT_W       = 4;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = WIDTH_CFG_W'(640);
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = HEIGHT_CFG_W'(480);

    localparam logic [LABEL_W-1:0] NONUNIFORM_LABEL = LABEL_W'(9);
    localparam logic [CNT_W-1:0]   MAX_CHANGES      = CNT_W'(2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH) + 1;

    // one classified neighborhood, ring order from top-left clockwise
    typedef struct packed {
        logic [RING_N-1:0] ring_bits;
        logic              frame_last;
    } lbp_entry_t;

endpackage

// File: hw/rtl/lbp_riu2_pixel_stream.sv
// ============================================================================
// LBP riu2 pixel stream
// Rotation-invariant uniform LBP (8 neighbors, radius 1) on a raster stream.
// ============================================================================
// Pixels of a frame enter one per clock in raster order while s_tready is
// high; each interior pixel yields one label on the output stream (0..8
// ones for a uniform pattern, 9 otherwise), border pixels yield nothing, and
// tlast marks the frame's last label. Sustained rate is one pixel per cycle
// while the output is taken. A label passes the line-store read port, the
// window update and the queue, after which it waits in the output register
// until taken.
// The front end takes a pixel only when the four-entry queue has a slot for
// every pixel in flight, so a stalled output backs up into s_tready. Line
// stores need no clearing pass after reset. Writing a configuration register
// restarts the frame at row zero, column zero.
module lbp_riu2_pixel_stream (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [3:0] pattern_label, [7:4] zero
    output logic                            m_tlast    // frame_last
);
    import lbp_pkg::*;

`include "lbp_riu2_pixel_stream_assert.svh"

    logic                   q_push;
    lbp_entry_t             q_in_entry;
    logic                   q_pop;
    logic                   q_valid;
    lbp_entry_t             q_out_entry;
    logic [QUEUE_CNT_W-1:0] q_count;
    logic [LABEL_W-1:0]     m_label;

    lbp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata[PIXEL_W-1:0]),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_entry   (q_in_entry)
    );

    lbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in_entry),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .out_entry  (q_out_entry),
        .count      (q_count)
    );

    lbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_out_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_label  (m_label),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(8 - LABEL_W){1'b0}}, m_label};

    `LBP_ASSERT_IMP(a_no_push_when_full, aclk, aresetn, q_push, q_count < QUEUE_CNT_W'(QUEUE_DEPTH))
    `LBP_ASSERT_IMP(a_count_bounded, aclk, aresetn, 1'b1, q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `LBP_ASSERT_NXT(a_queue_drains, aclk, aresetn, q_valid && (!m_tvalid || m_tready), m_tvalid)
    `LBP_ASSERT_IMP(a_label_range, aclk, aresetn, m_tvalid, m_label <= NONUNIFORM_LABEL)

endmodule

// File: hw/rtl/lbp_ram.sv
// ============================================================================
// LBP generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/lbp_front.sv
// ============================================================================
// LBP front end
// Accepts pixels, tracks raster position, keeps the line stores and 3x3
// window, and pushes the eight neighbor compare bits of interior pixels.
// ============================================================================
module lbp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lbp_pkg::PIXEL_W-1:0]   s_pixel,
    input  logic [lbp_pkg::QUEUE_CNT_W-1:0] q_count,
    output logic                          q_push,
    output lbp_pkg::lbp_entry_t           q_entry
);
    import lbp_pkg::*;

    logic [WIDTH_CFG_W-1:0]  width_cfg_reg;
    logic [HEIGHT_CFG_W-1:0] height_cfg_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;

    logic [WIDTH_CFG_W-1:0]  w_eff;
    logic [HEIGHT_CFG_W-1:0] h_eff;
    logic                    col_wrap;
    logic                    row_wrap;
    logic                    accept;
    logic [QUEUE_CNT_W-1:0]  pending;

    logic                    s1_valid_reg;
    logic [PIXEL_W-1:0]      s1_pixel_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_interior_reg;
    logic                    s1_last_reg;

    logic                    s2_valid_reg;
    logic                    s2_interior_reg;
    logic                    s2_last_reg;

    logic [PIXEL_W-1:0]      win_reg [9];
    logic [PIXEL_W-1:0]      top_rd;
    logic [PIXEL_W-1:0]      mid_rd;
    logic [RING_N-1:0]       ring_bits;

    always_comb begin
        if (width_cfg_reg > WIDTH_CFG_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_CFG_W'(MAX_WIDTH);
        end else if (width_cfg_reg == '0) begin
            w_eff = WIDTH_CFG_W'(1);
        end else begin
            w_eff = width_cfg_reg;
        end
        h_eff = (height_cfg_reg == '0) ? HEIGHT_CFG_W'(1) : height_cfg_reg;
    end

    assign col_wrap = ({1'b0, col_reg} + WIDTH_CFG_W'(1)) >= w_eff;
    assign row_wrap = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};

    // credit: every item in flight may still need a queue slot
    assign pending  = q_count + QUEUE_CNT_W'(s1_valid_reg) + QUEUE_CNT_W'(s2_valid_reg);
    assign s_tready = pending < QUEUE_CNT_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata[WIDTH_CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata[HEIGHT_CFG_W-1:0];
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pixel_reg    <= s_pixel;
        s1_col_reg      <= col_reg;
        s1_interior_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        s1_last_reg     <= col_wrap && row_wrap;
        s2_interior_reg <= s1_interior_reg;
        s2_last_reg     <= s1_last_reg;
    end

    // line stores: read at accept, rotate one row down in the next cycle
    lbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_addr (col_reg),
        .rd_data (top_rd)
    );

    lbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i*3]     <= win_reg[i*3 + 1];
                win_reg[i*3 + 1] <= win_reg[i*3 + 2];
            end
            win_reg[2] <= top_rd;
            win_reg[5] <= mid_rd;
            win_reg[8] <= s1_pixel_reg;
        end
    end

    // ring: top-left, top, top-right, right, bottom-right, bottom, bottom-left, left
    always_comb begin
        ring_bits[0] = win_reg[0] > win_reg[4];
        ring_bits[1] = win_reg[1] > win_reg[4];
        ring_bits[2] = win_reg[2] > win_reg[4];
        ring_bits[3] = win_reg[5] > win_reg[4];
        ring_bits[4] = win_reg[8] > win_reg[4];
        ring_bits[5] = win_reg[7] > win_reg[4];
        ring_bits[6] = win_reg[6] > win_reg[4];
        ring_bits[7] = win_reg[3] > win_reg[4];
    end

    assign q_push             = s2_valid_reg && s2_interior_reg;
    assign q_entry.ring_bits  = ring_bits;
    assign q_entry.frame_last = s2_last_reg;

endmodule

// File: hw/rtl/lbp_queue.sv
// ============================================================================
// LBP queue
// Short FIFO of classified neighborhoods between front and back end.
// ============================================================================
module lbp_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  lbp_pkg::lbp_entry_t             push_entry,
    input  logic                            pop,
    output logic                            out_valid,
    output lbp_pkg::lbp_entry_t             out_entry,
    output logic [lbp_pkg::QUEUE_CNT_W-1:0] count
);
    import lbp_pkg::*;

    lbp_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_pop;

    assign out_valid = count_reg != '0;
    assign do_pop    = pop && out_valid;
    assign out_entry = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/lbp_back.sv
// ============================================================================
// LBP back end
// Turns compare bits into the riu2 label and holds it in the output register.
// ============================================================================
module lbp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  lbp_pkg::lbp_entry_t         q_entry,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lbp_pkg::LABEL_W-1:0] m_label,
    output logic                        m_last
);
    import lbp_pkg::*;

    logic               m_valid_reg;
    logic [LABEL_W-1:0] label_reg;
    logic               last_reg;
    logic [RING_N-1:0]  bits;
    logic [RING_N-1:0]  flips;
    logic [CNT_W-1:0]   ones;
    logic [CNT_W-1:0]   changes;
    logic [LABEL_W-1:0] label_next;

    assign bits  = q_entry.ring_bits;
    // circular neighbor difference
    assign flips = bits ^ {bits[0], bits[RING_N-1:1]};

    always_comb begin
        ones    = '0;
        changes = '0;
        for (int k = 0; k < RING_N; k++) begin
            ones    = ones + CNT_W'(bits[k]);
            changes = changes + CNT_W'(flips[k]);
        end
        label_next = (changes <= MAX_CHANGES) ? LABEL_W'(ones) : NONUNIFORM_LABEL;
    end

    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            label_reg <= label_next;
            last_reg  <= q_entry.frame_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_label  = label_reg;
    assign m_last   = last_reg;

endmodule
